[rtl/core/upc_pkg.sv]
`default_nettype none
package upc_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  localparam int unsigned MaxResults = 3;

  // Register index as decoded from paddr.
  localparam logic REG_MODE = 1'b0;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PCT  = 2'd1,
    PH_HIGH = 2'd2
  } phase_e;

  // Results of one input item plus the escape state it leaves behind.
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] bytes;
    logic            last;
    phase_e          phase;
    logic [3:0]      nibble;
  } conv_res_t;

  function automatic logic is_unreserved(input logic [7:0] c);
    logic r;
    r = (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UZ) ||
        (c >= CH_LA && c <= CH_LZ) || c == CH_DASH || c == CH_UNDER ||
        c == CH_DOT || c == CH_TILDE;
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] w;
    w = {4'b0000, v};
    return (w < HEX_TEN) ? CH_ZERO + w : CH_UA + w - HEX_TEN;
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + HEX_TEN;
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + HEX_TEN;
    end
    return d[3:0];
  endfunction

endpackage
`default_nettype wire

[rtl/core/url_percent_codec.sv]
// Channel   Dir  Payload                          Handshake
// s_*       in   tdata: in_byte[7:0]; tlast       s_tvalid_i / s_tready_o
// m_*       out  tdata: out_byte[7:0]; tlast      m_tvalid_o / m_tready_i
// APB       in   reg 0 at 0x0: mode[0]            psel_i, penable_i, pready_o
//
// An item is held in an input register, converted in one pass and its
// results (up to three bytes) loaded into an output buffer that sends one
// byte per cycle while m_tready_i is high. Encoding yields 1 or 3 bytes
// per item; decoding yields 0 to 2. Reset clears mode, escape state and
// both valid flags. The input register takes the next item while the
// buffer still holds results, and stalls only when both are occupied.
`default_nettype none
module url_percent_codec (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [7:0]  s_tdata_i,   // in_byte[7:0]
  input  wire logic        s_tlast_i,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [7:0]       m_tdata_o,   // out_byte[7:0]
  output logic             m_tlast_o,
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);

  upc_pkg::mode_e     mode_q, mode_d;
  upc_pkg::phase_e    phase_q, phase_d;
  logic [3:0]         nibble_q, nibble_d;
  logic               in_valid_q, in_valid_d;
  logic [7:0]         in_byte_q;
  logic               in_last_q;
  logic               ob_free;
  logic               consume;
  logic               cfg_wr;
  upc_pkg::conv_res_t res;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o &&
                    (paddr_i[2] == upc_pkg::REG_MODE);
  assign prdata_o = (paddr_i[2] == upc_pkg::REG_MODE) ? {31'd0, mode_q} : 32'd0;

  assign consume    = in_valid_q && ob_free;
  assign s_tready_o = !in_valid_q || consume;

  upc_convert u_convert (
    .mode_i   (mode_q),
    .phase_i  (phase_q),
    .nibble_i (nibble_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .res_o    (res)
  );

  upc_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (consume),
    .res_i      (res),
    .free_o     (ob_free),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  always_comb begin
    mode_d     = mode_q;
    phase_d    = phase_q;
    nibble_d   = nibble_q;
    in_valid_d = in_valid_q;
    if (consume) begin
      phase_d    = res.phase;
      nibble_d   = res.nibble;
      in_valid_d = 1'b0;
    end
    if (s_tvalid_i && s_tready_o) begin
      in_valid_d = 1'b1;
    end
    // A mode write abandons any pending escape.
    if (cfg_wr) begin
      mode_d   = upc_pkg::mode_e'(pwdata_i[0]);
      phase_d  = upc_pkg::PH_IDLE;
      nibble_d = 4'h0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= upc_pkg::MODE_ENCODE;
      phase_q    <= upc_pkg::PH_IDLE;
      nibble_q   <= 4'h0;
      in_valid_q <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      phase_q    <= phase_d;
      nibble_q   <= nibble_d;
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      in_byte_q <= s_tdata_i;
      in_last_q <= s_tlast_i;
    end
  end

  a_escape_only_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != upc_pkg::PH_IDLE |-> mode_q == upc_pkg::MODE_DECODE)
    else $error("escape pending while encoding");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == upc_pkg::PH_IDLE || phase_q == upc_pkg::PH_PCT ||
    phase_q == upc_pkg::PH_HIGH)
    else $error("unreachable escape phase");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && in_last_q |=> phase_q == upc_pkg::PH_IDLE && nibble_q == 4'h0)
    else $error("escape state survives end of string");

endmodule
`default_nettype wire

[rtl/core/upc_convert.sv]
`default_nettype none
module upc_convert (
  input  wire upc_pkg::mode_e     mode_i,
  input  wire upc_pkg::phase_e    phase_i,
  input  wire logic [3:0]         nibble_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic               last_i,
  output upc_pkg::conv_res_t      res_o
);

  logic [7:0] plain;

  // A byte outside an escape: '+' decodes to a space, all else passes.
  assign plain = (byte_i == upc_pkg::CH_PLUS) ? upc_pkg::CH_SPACE : byte_i;

  always_comb begin
    res_o        = '0;
    res_o.last   = last_i;
    res_o.phase  = phase_i;
    res_o.nibble = nibble_i;
    if (mode_i == upc_pkg::MODE_ENCODE) begin
      if (upc_pkg::is_unreserved(byte_i)) begin
        res_o.count    = 2'd1;
        res_o.bytes[0] = byte_i;
      end else if (byte_i == upc_pkg::CH_SPACE) begin
        res_o.count    = 2'd1;
        res_o.bytes[0] = upc_pkg::CH_PLUS;
      end else begin
        res_o.count    = 2'd3;
        res_o.bytes[0] = upc_pkg::CH_PCT;
        res_o.bytes[1] = upc_pkg::hex_digit(byte_i[7:4]);
        res_o.bytes[2] = upc_pkg::hex_digit(byte_i[3:0]);
      end
    end else begin
      case (phase_i)
        upc_pkg::PH_PCT: begin
          if (last_i) begin
            res_o.count    = 2'd2;
            res_o.bytes[0] = upc_pkg::CH_PCT;
            res_o.bytes[1] = plain;
          end else begin
            res_o.nibble = upc_pkg::hex_value(byte_i);
            res_o.phase  = upc_pkg::PH_HIGH;
          end
        end
        upc_pkg::PH_HIGH: begin
          res_o.count    = 2'd1;
          res_o.bytes[0] = {nibble_i, upc_pkg::hex_value(byte_i)};
          res_o.phase    = upc_pkg::PH_IDLE;
          res_o.nibble   = 4'h0;
        end
        default: begin
          res_o.phase = upc_pkg::PH_IDLE;
          if (byte_i == upc_pkg::CH_PCT && !last_i) begin
            res_o.phase = upc_pkg::PH_PCT;
          end else begin
            res_o.count    = 2'd1;
            res_o.bytes[0] = plain;
          end
        end
      endcase
    end
    if (last_i) begin
      res_o.phase  = upc_pkg::PH_IDLE;
      res_o.nibble = 4'h0;
    end
  end

endmodule
`default_nettype wire

[rtl/core/upc_outbuf.sv]
`default_nettype none
module upc_outbuf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire upc_pkg::conv_res_t res_i,
  output logic                    free_o,
  output logic                    m_tvalid_o,
  input  wire logic               m_tready_i,
  output logic [7:0]              m_tdata_o,
  output logic                    m_tlast_o
);

  logic [2:0][7:0] slot_q, slot_d;
  logic [1:0]      rem_q, rem_d;
  logic            last_q, last_d;
  logic            pop;

  assign pop        = m_tvalid_o && m_tready_i;
  assign m_tvalid_o = (rem_q != 2'd0);
  assign m_tdata_o  = slot_q[0];
  assign m_tlast_o  = last_q && (rem_q == 2'd1);
  // The buffer can take a new item's results once its last byte leaves.
  assign free_o     = (rem_q == 2'd0) || (rem_q == 2'd1 && m_tready_i);

  always_comb begin
    slot_d = slot_q;
    rem_d  = rem_q;
    last_d = last_q;
    if (load_i) begin
      slot_d = res_i.bytes;
      rem_d  = res_i.count;
      last_d = res_i.last;
    end else if (pop) begin
      slot_d = {8'h00, slot_q[2], slot_q[1]};
      rem_d  = rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= 2'd0;
      last_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> rem_q == 2'd0 || (rem_q == 2'd1 && pop))
    else $error("results loaded over bytes not yet delivered");

endmodule
`default_nettype wire
